@@ hdl/adpf_pkg.sv @@
`timescale 1ns / 1ps
package adpf_pkg;

  typedef struct packed {
    logic [15:0] qidx;
    logic [19:0] sidx;
    logic [23:0] s_start;
    logic [23:0] s_end;
    logic [23:0] q_start;
    logic [23:0] q_end;
    logic [23:0] len;
    logic [31:0] db_start;
    logic [31:0] db_end;
  } hit_t;

  typedef struct packed {
    logic rotate;
    logic clear_rm;
  } ring_ctl_t;

  localparam logic [1:0] KIND_INSERTED = 2'd0;
  localparam logic [1:0] KIND_DUP      = 2'd1;
  localparam logic [1:0] KIND_FULL     = 2'd2;
  localparam logic [1:0] KIND_HIT      = 2'd3;

  // tolerance is 2 * (length / 20), length / 20 = (length >> 2) / 5, the divide
  // by 5 done as a multiply by ceil(2^26 / 5), exact for all 22-bit operands
  localparam logic [23:0] TOL_RECIP = 24'd13421773;
  localparam int          TOL_SHIFT = 26;

endpackage

@@ hdl/alignment_dedup_prune_filter_unit.sv @@
`timescale 1ns / 1ps
// plain hit: the beat is registered, checked in S_CHK, then its result is registered
// last hit: insert check, then pruning with each of the n stored hits as pivot,
//   then one ring pass before each surviving hit is shown
// flow: one hit in flight at a time, no new beat until all results leave;
//   a plain hit goes back to idle as soon as its result is taken
// reset: rst_n synchronous active low, clears fill count, marks and control;
//   hit payload in the cells is not reset
module alignment_dedup_prune_filter_unit import adpf_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // query_index, subject_index, subject_start, subject_end, query_start,
  // query_end, hit_length, db_query_start, db_query_end, zero pad
  input  logic [223:0] in_tdata,
  input  logic         in_tlast,   // last_hit
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_query_index, out_subject_index, out_subject_start, out_subject_end,
  // out_query_start, out_query_end, out_length, out_db_query_start,
  // out_db_query_end, zero pad
  output logic [223:0] out_tdata,
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast   // last_out
);

  localparam int IW = $clog2(DEPTH + 1);  // fill count, 0..DEPTH
  localparam int XW = $clog2(DEPTH);      // entry index

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_PR   = 3'd3;
  localparam logic [2:0] S_SEL  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  function automatic hit_t unpack_hit(input logic [223:0] d);
    hit_t h;
    h.qidx     = d[15:0];
    h.sidx     = d[35:16];
    h.s_start  = d[59:36];
    h.s_end    = d[83:60];
    h.q_start  = d[107:84];
    h.q_end    = d[131:108];
    h.len      = d[155:132];
    h.db_start = d[187:156];
    h.db_end   = d[219:188];
    return h;
  endfunction

  function automatic logic [223:0] pack_hit(input hit_t h);
    return {4'b0, h.db_end, h.db_start, h.len, h.q_end, h.q_start,
            h.s_end, h.s_start, h.sidx, h.qidx};
  endfunction

  logic [2:0]    state_r;
  logic [IW-1:0] count_r;
  hit_t          in_hit_r;
  logic          last_r;
  logic [1:0]    kind_r;
  logic          ins_pend_r;
  logic [XW-1:0] k_r;       // pivot entry
  logic [IW-1:0] c_r;       // step within a ring pass
  logic          ph_r;      // tolerance stage, then decide
  hit_t          pv_hit_r;
  logic          pv_rm_r;
  logic          pv_skip_r;
  logic [XW-1:0] prev_idx_r;
  logic          have_prev_r;
  hit_t          best_hit_r;
  logic [XW-1:0] best_idx_r;
  logic          found_r;
  logic [IW-1:0] rem_r;     // survivors left, counted in the last pass
  logic          best_sent_r;
  logic          out_valid_r;
  logic [223:0]  out_data_r;
  logic [1:0]    out_kind_r;
  logic          out_last_r;

  // ring of cells, cell 0 is the head
  hit_t          c_hit [DEPTH];
  logic [XW-1:0] c_idx [DEPTH];
  logic          c_rm  [DEPTH];
  logic [DEPTH-1:0] c_dup;

  ring_ctl_t     ctl;
  hit_t          head_hit;
  logic [XW-1:0] head_idx;
  logic          head_rm;
  logic          wrap_rm;
  logic          dup_any;
  logic          ins_we;
  logic [1:0]    kind_now;
  logic          cmp_en;
  logic          hit_cov;
  logic          a_longer;
  logic          is_emitted;
  logic          elig;
  logic          less;
  logic          found_cur;
  logic [IW-1:0] rem_cur;
  logic          prune_mid;

  assign head_hit = c_hit[0];
  assign head_idx = c_idx[0];
  assign head_rm  = c_rm[0];
  assign dup_any  = |c_dup;

  always_comb begin
    if (dup_any) begin
      kind_now = KIND_DUP;
    end else if (count_r >= IW'(DEPTH)) begin
      kind_now = KIND_FULL;
    end else begin
      kind_now = KIND_INSERTED;
    end
  end

  assign ins_we = (state_r == S_CHK) && (kind_now == KIND_INSERTED);

  // middle of a pivot walk: one of the other entries sits at the head
  assign prune_mid = (c_r != '0) && (c_r != count_r);
  assign cmp_en    = !pv_skip_r && !head_rm && (head_idx > k_r) &&
                     (head_hit.qidx == pv_hit_r.qidx) && (head_hit.sidx == pv_hit_r.sidx);

  assign is_emitted = have_prev_r && (head_idx == prev_idx_r);
  assign elig       = !head_rm && !is_emitted;
  assign less       = {head_hit.qidx, head_hit.sidx, head_hit.db_start, head_hit.db_end} <
                      {best_hit_r.qidx, best_hit_r.sidx, best_hit_r.db_start, best_hit_r.db_end};
  assign found_cur  = (c_r == '0) ? 1'b0 : found_r;
  assign rem_cur    = (c_r == '0) ? '0 : rem_r;

  always_comb begin
    ctl.rotate   = 1'b0;
    ctl.clear_rm = 1'b0;
    wrap_rm      = head_rm;
    unique case (state_r)
      S_PR: begin
        ctl.rotate = !prune_mid || ph_r;
        if (c_r == count_r) begin
          wrap_rm = pv_rm_r;  // write the pivot's mark back
        end else if (prune_mid && ph_r && cmp_en && hit_cov && a_longer) begin
          wrap_rm = 1'b1;
        end
      end
      S_SEL: begin
        ctl.rotate = 1'b1;
        wrap_rm    = head_rm | is_emitted;
      end
      S_EMIT: begin
        ctl.clear_rm = !ins_pend_r && (rem_r == '0);
      end
      default: begin
      end
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      hit_t          nb_hit;
      logic [XW-1:0] nb_idx;
      logic          nb_rm;
      if (gi == DEPTH - 1) begin : g_end
        assign nb_hit = head_hit;
        assign nb_idx = head_idx;
        assign nb_rm  = wrap_rm;
      end else begin : g_mid
        assign nb_hit = c_hit[gi+1];
        assign nb_idx = c_idx[gi+1];
        assign nb_rm  = c_rm[gi+1];
      end
      adpf_cell #(.XW(XW)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .active   (IW'(gi) < count_r),
        .is_tail  (IW'(gi) == count_r - IW'(1)),
        .wr_en    (ins_we && (IW'(gi) == count_r)),
        .wr_hit   (in_hit_r),
        .wr_idx   (XW'(count_r)),
        .nb_hit   (nb_hit),
        .nb_idx   (nb_idx),
        .nb_rm    (nb_rm),
        .wrap_hit (head_hit),
        .wrap_idx (head_idx),
        .wrap_rm  (wrap_rm),
        .probe    (in_hit_r),
        .hit      (c_hit[gi]),
        .idx      (c_idx[gi]),
        .rm       (c_rm[gi]),
        .dup      (c_dup[gi])
      );
    end
  endgenerate

  adpf_prune_unit u_prune (
    .clk      (clk),
    .calc     ((state_r == S_PR) && prune_mid && !ph_r),
    .a        (pv_hit_r),
    .b        (head_hit),
    .hit_cov  (hit_cov),
    .a_longer (a_longer)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ins_pend_r  <= 1'b0;
      have_prev_r <= 1'b0;
      best_sent_r <= 1'b0;
      found_r     <= 1'b0;
      ph_r        <= 1'b0;
      c_r         <= '0;
      k_r         <= '0;
      rem_r       <= '0;
      last_r      <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            in_hit_r <= unpack_hit(in_tdata);
            last_r   <= in_tlast;
            state_r  <= S_CHK;
          end
        end
        S_CHK: begin
          if (ins_we) begin
            count_r <= count_r + IW'(1);
          end
          if (last_r) begin
            kind_r     <= kind_now;
            ins_pend_r <= 1'b1;
            k_r        <= '0;
            c_r        <= '0;
            ph_r       <= 1'b0;
            state_r    <= S_PR;
          end else begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            out_kind_r  <= kind_now;
            out_last_r  <= 1'b1;
            state_r     <= S_WAIT;
          end
        end
        S_PR: begin
          if (c_r == '0) begin
            pv_hit_r  <= head_hit;
            pv_rm_r   <= head_rm;
            pv_skip_r <= head_rm;
            c_r       <= c_r + IW'(1);
          end else if (c_r == count_r) begin
            c_r <= '0;
            if (IW'(k_r) == count_r - IW'(1)) begin
              have_prev_r <= 1'b0;
              state_r     <= S_SEL;
            end else begin
              k_r <= k_r + XW'(1);
            end
          end else if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            c_r  <= c_r + IW'(1);
            if (cmp_en && hit_cov && !a_longer) begin
              pv_rm_r <= 1'b1;  // ties remove the pivot
            end
          end
        end
        S_SEL: begin
          if (elig) begin
            rem_r <= rem_cur + IW'(1);
            if (!found_cur || less) begin
              best_hit_r <= head_hit;
              best_idx_r <= head_idx;
            end
            found_r <= 1'b1;
          end else begin
            rem_r   <= rem_cur;
            found_r <= found_cur;
          end
          if (c_r == count_r - IW'(1)) begin
            c_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            c_r <= c_r + IW'(1);
          end
        end
        S_EMIT: begin
          if (ins_pend_r) begin
            ins_pend_r  <= 1'b0;
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            out_kind_r  <= kind_r;
            out_last_r  <= (rem_r == '0);
            state_r     <= S_WAIT;
          end else if (rem_r == '0) begin
            count_r     <= '0;
            have_prev_r <= 1'b0;
            best_sent_r <= 1'b0;
            state_r     <= S_IDLE;
          end else if (!best_sent_r) begin
            best_sent_r <= 1'b1;
            out_valid_r <= 1'b1;
            out_data_r  <= pack_hit(best_hit_r);
            out_kind_r  <= KIND_HIT;
            out_last_r  <= (rem_r == IW'(1));
            state_r     <= S_WAIT;
          end else begin
            best_sent_r <= 1'b0;
            prev_idx_r  <= best_idx_r;
            have_prev_r <= 1'b1;
            c_r         <= '0;
            state_r     <= S_SEL;
          end
        end
        S_WAIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= last_r ? S_EMIT : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IW'(DEPTH))
    else $error("fill count above depth");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while a result is pending");

  a_accept_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CHK))
    else $error("accepted beat not checked");

  a_hit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_HIT)) |-> last_r)
    else $error("survivor shown outside a last hit");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");
`endif

endmodule

@@ hdl/adpf_cell.sv @@
`timescale 1ns / 1ps
module adpf_cell import adpf_pkg::*; #(
  parameter int XW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ring_ctl_t     ctl,
  input  logic          active,
  input  logic          is_tail,
  input  logic          wr_en,
  input  hit_t          wr_hit,
  input  logic [XW-1:0] wr_idx,
  input  hit_t          nb_hit,
  input  logic [XW-1:0] nb_idx,
  input  logic          nb_rm,
  input  hit_t          wrap_hit,
  input  logic [XW-1:0] wrap_idx,
  input  logic          wrap_rm,
  input  hit_t          probe,
  output hit_t          hit,
  output logic [XW-1:0] idx,
  output logic          rm,
  output logic          dup
);

  hit_t          hit_r;
  logic [XW-1:0] idx_r;
  logic          rm_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hit_r <= wr_hit;
      idx_r <= wr_idx;
    end else if (ctl.rotate && active) begin
      hit_r <= is_tail ? wrap_hit : nb_hit;
      idx_r <= is_tail ? wrap_idx : nb_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_r <= 1'b0;
    end else if (ctl.clear_rm || wr_en) begin
      rm_r <= 1'b0;
    end else if (ctl.rotate && active) begin
      rm_r <= is_tail ? wrap_rm : nb_rm;
    end
  end

  assign dup = active && (hit_r.qidx == probe.qidx) && (hit_r.sidx == probe.sidx) &&
               (hit_r.s_start == probe.s_start) && (hit_r.s_end == probe.s_end) &&
               (hit_r.q_start == probe.q_start) && (hit_r.q_end == probe.q_end);

  assign hit = hit_r;
  assign idx = idx_r;
  assign rm  = rm_r;

endmodule

@@ hdl/adpf_prune_unit.sv @@
`timescale 1ns / 1ps
module adpf_prune_unit import adpf_pkg::*; (
  input  logic clk,
  input  logic calc,
  input  hit_t a,
  input  hit_t b,
  output logic hit_cov,
  output logic a_longer
);

  logic [23:0] mn;
  logic [45:0] prod;
  logic [19:0] sh_r;
  logic [25:0] sh2;

  function automatic logic covers(input hit_t x, input hit_t y, input logic [25:0] s2);
    logic c0, c1, c2, c3;
    c0 = ({2'b00, x.s_end} + s2) >= {2'b00, y.s_end};
    c1 = {2'b00, x.s_start} <= ({2'b00, y.s_start} + s2);
    c2 = ({2'b00, x.q_end} + s2) >= {2'b00, y.q_end};
    c3 = {2'b00, x.q_start} <= ({2'b00, y.q_start} + s2);
    return c0 && c1 && c2 && c3;
  endfunction

  assign mn   = (a.len < b.len) ? a.len : b.len;
  assign prod = 46'(mn[23:2]) * 46'(TOL_RECIP);

  always_ff @(posedge clk) begin
    if (calc) begin
      sh_r <= prod[45:TOL_SHIFT];
    end
  end

  assign sh2      = {5'b0, sh_r, 1'b0};
  assign hit_cov  = covers(a, b, sh2) || covers(b, a, sh2);
  assign a_longer = a.len > b.len;

endmodule
